// ----- src/dbpd_pkg.sv -----
// Shared types and constants for the delta block pixel decoder.
// Used by dbpd_ctrl, dbpd_datapath and delta_block_pixel_decoder_core.
package dbpd_pkg;

    localparam int BYTE_W               = 8;
    localparam int WIDTH_W              = 4;
    localparam int WIDTH_LSB            = 1;
    localparam int MAX_DELTA_WIDTH      = 8;
    localparam int HELD_W               = 5;
    localparam int BUF_W                = 16;
    localparam int CFG_W                = 7;
    localparam int DEF_MAX_BLOCK_PIXELS = 64;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [1:0]
    {
        PH_HEADER = 2'd0,
        PH_FIRST  = 2'd1,
        PH_DELTA  = 2'd2
    } dbpd_phase_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_STEP = 1'b1
    } dbpd_state_t;

    typedef struct packed
    {
        logic load;
        logic step;
        logic finish;
    } dbpd_cmd_t;

    typedef struct packed
    {
        logic has_work;
        logic out_free;
    } dbpd_sts_t;

endpackage

// ----- src/dbpd_ctrl.sv -----
// Controller state machine for the delta block pixel decoder.
// Depends on dbpd_pkg; drives the command struct of dbpd_datapath.
module dbpd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  dbpd_pkg::dbpd_sts_t sts,
    output dbpd_pkg::dbpd_cmd_t cmd
);
    import dbpd_pkg::*;

    dbpd_state_t state_reg;
    dbpd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (!sts.has_work)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_STEP:
            begin
                cmd.step   = sts.has_work && sts.out_free;
                cmd.finish = !sts.has_work;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_to_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_STEP)
        else $error("accepted transfer did not start processing");
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && !sts.has_work) |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle");
    a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> sts.out_free)
        else $error("pixel issued into a full output register");
`endif

endmodule

// ----- src/dbpd_datapath.sv -----
// Datapath of the delta block pixel decoder: block state, bit buffer,
// delta extraction and output register. Depends on dbpd_pkg.
module dbpd_datapath
#(
    parameter int MAX_BLOCK_PIXELS = dbpd_pkg::DEF_MAX_BLOCK_PIXELS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [dbpd_pkg::BYTE_W-1:0]      in_byte,
    input  logic                             in_begin,
    input  logic                             cfg_we,
    input  logic [dbpd_pkg::CFG_W-1:0]       cfg_wdata,
    input  dbpd_pkg::dbpd_cmd_t              cmd,
    output dbpd_pkg::dbpd_sts_t              sts,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dbpd_pkg::BYTE_W-1:0]      out_pixel,
    output logic                             out_last,
    output logic                             out_bad
);
    import dbpd_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK_PIXELS + 1);

    logic [CFG_W-1:0]   ppb_reg;
    dbpd_phase_t        phase_reg, phase_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [BYTE_W-1:0]  prev_reg, prev_next;
    logic [BUF_W-1:0]   buf_reg, buf_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]   done_reg, done_next;
    logic               bad_pend_reg, bad_pend_next;
    logic               first_pend_reg, first_pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_pixel_reg, out_pixel_next;
    logic               out_last_reg, out_last_next;
    logic               out_bad_reg, out_bad_next;

    logic [CFG_W-1:0]   ppb_clamp;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   done_inc;
    logic               last_hit;
    logic [WIDTH_W-1:0] hdr_width;
    logic [HELD_W-1:0]  shift_amt;
    logic [BUF_W-1:0]   field;
    logic [BYTE_W-1:0]  mask8;
    logic [BYTE_W-1:0]  v8;
    logic               sign_bit;
    logic [BYTE_W-1:0]  delta8;
    logic [BYTE_W-1:0]  drain_pix;
    logic [HELD_W-1:0]  held_left;
    logic [BUF_W-1:0]   keep_mask;
    logic               drain_ok;
    logic               out_free;

    always_comb
    begin
        if (ppb_reg == '0)
        begin
            ppb_clamp = CFG_W'(1);
        end
        else if (ppb_reg > CFG_W'(MAX_BLOCK_PIXELS))
        begin
            ppb_clamp = CFG_W'(MAX_BLOCK_PIXELS);
        end
        else
        begin
            ppb_clamp = ppb_reg;
        end
    end

    assign cnt       = CNT_W'(ppb_clamp);
    assign done_inc  = done_reg + CNT_W'(1);
    assign last_hit  = done_inc >= cnt;
    assign hdr_width = in_byte[WIDTH_LSB +: WIDTH_W];

    assign shift_amt = held_reg - HELD_W'(width_reg);
    assign field     = buf_reg >> shift_amt;
    assign mask8     = BYTE_W'((9'd1 << width_reg) - 9'd1);
    assign v8        = field[BYTE_W-1:0] & mask8;
    assign sign_bit  = (width_reg != '0) && field[4'(width_reg - 4'd1)];
    assign delta8    = sign_bit ? (v8 | ~mask8) : v8;
    assign drain_pix = prev_reg + delta8;
    assign held_left = held_reg - HELD_W'(width_reg);
    assign keep_mask = BUF_W'((17'd1 << held_left) - 17'd1);

    assign drain_ok = (phase_reg == PH_DELTA) && (done_reg < cnt)
                      && (held_reg >= HELD_W'(width_reg));
    assign out_free = !out_valid_reg || out_ready;

    assign sts.has_work = bad_pend_reg || first_pend_reg || drain_ok;
    assign sts.out_free = out_free;

    always_comb
    begin
        phase_next      = phase_reg;
        width_next      = width_reg;
        prev_next       = prev_reg;
        buf_next        = buf_reg;
        held_next       = held_reg;
        done_next       = done_reg;
        bad_pend_next   = bad_pend_reg;
        first_pend_next = first_pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_pixel_next  = out_pixel_reg;
        out_last_next   = out_last_reg;
        out_bad_next    = out_bad_reg;

        if (cmd.load)
        begin
            if (in_begin)
            begin
                buf_next   = '0;
                held_next  = '0;
                done_next  = '0;
                width_next = hdr_width;
                if (hdr_width > WIDTH_W'(MAX_DELTA_WIDTH))
                begin
                    phase_next    = PH_HEADER;
                    bad_pend_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_FIRST;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        prev_next       = in_byte;
                        done_next       = '0;
                        buf_next        = '0;
                        held_next       = '0;
                        first_pend_next = 1'b1;
                        phase_next      = PH_DELTA;
                    end
                    PH_DELTA:
                    begin
                        if (done_reg >= cnt)
                        begin
                            phase_next = PH_HEADER;
                            buf_next   = '0;
                            held_next  = '0;
                        end
                        else
                        begin
                            buf_next  = {buf_reg[BUF_W-BYTE_W-1:0], in_byte};
                            held_next = held_reg + HELD_W'(BYTE_W);
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (cmd.step)
        begin
            out_valid_next = 1'b1;
            if (bad_pend_reg)
            begin
                out_pixel_next = '0;
                out_last_next  = 1'b1;
                out_bad_next   = 1'b1;
                bad_pend_next  = 1'b0;
            end
            else if (first_pend_reg)
            begin
                out_pixel_next  = prev_reg;
                out_last_next   = last_hit;
                out_bad_next    = 1'b0;
                done_next       = done_inc;
                first_pend_next = 1'b0;
            end
            else
            begin
                out_pixel_next = drain_pix;
                out_last_next  = last_hit;
                out_bad_next   = 1'b0;
                prev_next      = drain_pix;
                held_next      = held_left;
                buf_next       = buf_reg & keep_mask;
                done_next      = done_inc;
            end
        end

        if (cmd.finish && (done_reg >= cnt))
        begin
            phase_next = PH_HEADER;
            buf_next   = '0;
            held_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppb_reg        <= CFG_RESET;
            phase_reg      <= PH_HEADER;
            width_reg      <= '0;
            prev_reg       <= '0;
            buf_reg        <= '0;
            held_reg       <= '0;
            done_reg       <= '0;
            bad_pend_reg   <= 1'b0;
            first_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ppb_reg <= cfg_wdata;
            end
            phase_reg      <= phase_next;
            width_reg      <= width_next;
            prev_reg       <= prev_next;
            buf_reg        <= buf_next;
            held_reg       <= held_next;
            done_reg       <= done_next;
            bad_pend_reg   <= bad_pend_next;
            first_pend_reg <= first_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pixel_reg <= out_pixel_next;
        out_last_reg  <= out_last_next;
        out_bad_reg   <= out_bad_next;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;
    assign out_bad   = out_bad_reg;

`ifndef SYNTHESIS
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg < HELD_W'(BUF_W))
        else $error("bit buffer overfilled");
    a_bad_output: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> (out_last_reg && out_pixel_reg == '0))
        else $error("error result malformed");
    a_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(bad_pend_reg && first_pend_reg))
        else $error("error and first pixel pending together");
`endif

endmodule

// ----- src/delta_block_pixel_decoder_core.sv -----
// Top level of the delta block pixel decoder.
// Depends on dbpd_pkg, dbpd_ctrl and dbpd_datapath.
//
// Usage:
//   s_* carries the compressed byte stream: s_tdata is the stream byte,
//   s_tuser is set on the header byte of a block. m_* returns decoded
//   pixels: m_tdata is the pixel, m_tlast marks the final pixel of a block
//   (or the error result), m_tuser flags a header delta width above eight.
//   cfg_* writes the pixels-per-block register; write it only while idle.
// Timing:
//   An input byte is accepted by a load step in the idle state; it then
//   yields its pixels and a closing step returns the controller to idle.
//   No new byte is accepted before that. The single delta-extraction
//   step in the datapath yields one pixel per cycle while the output
//   register is free; each result is registered there before it appears.
// Reset:
//   rst_n clears the block state, the output valid and sets the register
//   to 64 pixels per block. When m_tready is low the result holds in the
//   output register and decoding pauses until it is taken.
module delta_block_pixel_decoder_core
#(
    parameter int MAX_BLOCK_PIXELS = dbpd_pkg::DEF_MAX_BLOCK_PIXELS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dbpd_pkg::BYTE_W-1:0]   s_tdata,  // [7:0] stream_byte
    input  logic                          s_tuser,  // [0] block_begin
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dbpd_pkg::BYTE_W-1:0]   m_tdata,  // [7:0] pixel
    output logic                          m_tlast,
    output logic                          m_tuser,  // [0] bad_width
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dbpd_pkg::CFG_W-1:0]    cfg_data
);
    import dbpd_pkg::*;

    dbpd_cmd_t cmd;
    dbpd_sts_t sts;

    assign cfg_ready = 1'b1;

    dbpd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dbpd_datapath
    #(
        .MAX_BLOCK_PIXELS (MAX_BLOCK_PIXELS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_tdata),
        .in_begin  (s_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_wdata (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata),
        .out_last  (m_tlast),
        .out_bad   (m_tuser)
    );

endmodule
